// File: sv/ssds_pkg.sv
package ssds_pkg;

   // light sample width, fixed by the converter feeding the block
   localparam int SAMPLE_BITS = 12;

   // stream payload widths, padded to whole bytes
   localparam int REQ_TDATA_W = 24;
   localparam int RSP_TDATA_W = 32;

   // angle landmarks of one sweep cycle
   localparam logic [7:0] ANGLE_REST = 8'd120;
   localparam logic [7:0] ANGLE_TOP  = 8'd180;

   // register reset values
   localparam logic [SAMPLE_BITS-1:0] RISE_RESET  = SAMPLE_BITS'(600);
   localparam logic [SAMPLE_BITS-1:0] FALL_RESET  = SAMPLE_BITS'(500);
   localparam logic [7:0]             TPS_RESET   = 8'd5;
   localparam logic [9:0]             PAUSE_RESET = 10'd500;

   typedef enum logic [1:0] {
      CSR_RISE  = 2'd0,
      CSR_FALL  = 2'd1,
      CSR_TPS   = 2'd2,
      CSR_PAUSE = 2'd3
   } csr_index_type;

   typedef enum logic {
      REQ_START = 1'b0,
      REQ_TICK  = 1'b1
   } req_kind_type;

   typedef enum logic [1:0] {
      LEG_DOWN   = 2'd0,
      LEG_PAUSE  = 2'd1,
      LEG_UP     = 2'd2,
      LEG_RETURN = 2'd3
   } leg_type;

   typedef struct packed {
      logic [SAMPLE_BITS-1:0] rise;
      logic [SAMPLE_BITS-1:0] fall;
      logic [7:0]             tps;
      logic [9:0]             pause;
   } cfg_type;

   typedef struct packed {
      req_kind_type           kind;
      logic [1:0]             servo;
      logic [7:0]             amount;
      logic [SAMPLE_BITS-1:0] sample;
      logic                   button;
   } item_type;

   typedef struct packed {
      logic        active;
      leg_type     leg;
      logic [7:0]  angle;
      logic [9:0]  hold;
      logic [9:0]  cycles;
      logic [7:0]  target;
      logic [1:0]  servo;
      logic        det_high;
      logic [15:0] count;
   } seq_state_type;

   typedef struct packed {
      logic        running;
      logic [1:0]  channel;
      logic [7:0]  angle;
      logic        led;
      logic [15:0] count;
      logic        done;
   } result_type;

endpackage

// File: sv/servo_sweep_dispense_sequencer.sv
// an accepted item is held in the input register, and its result is registered in the
// result register; one item per cycle while the result side is not stalled; the state update
// is a single pass through the step logic between the input register and the result register
// reset (synchronous, active high) clears the run state, loads the default
// thresholds, step and pause lengths, and empties both registers
module servo_sweep_dispense_sequencer
   import ssds_pkg::*;
#(
   parameter int NUM_SERVOS = 4
)(
   input  logic                   clock,
   input  logic                   reset,
   // configuration writes
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [1:0]             csr_index,
   input  logic [11:0]            csr_wdata,
   // request items
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,  // servo_select, dispense_amount, light_sample,
                                              // button_press
   input  logic                   req_tuser,  // req_type
   // result items
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,  // running, servo_channel, servo_angle, led_on,
                                              // dispensed_count
   output logic                   rsp_tlast   // run_done
);

   localparam logic [4:0] NumServosW = 5'(NUM_SERVOS);
   localparam logic [1:0] MaxSel     = 2'(NUM_SERVOS - 1);

   cfg_type       cfg_ff;
   logic          in_valid_ff;
   item_type      in_item_ff;
   item_type      in_item_in;
   seq_state_type state_ff;
   seq_state_type state_in;
   logic          out_valid_ff;
   result_type    out_res_ff;
   result_type    step_res;
   logic          out_adv;
   logic          fire;

   // configuration registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.rise  <= RISE_RESET;
         cfg_ff.fall  <= FALL_RESET;
         cfg_ff.tps   <= TPS_RESET;
         cfg_ff.pause <= PAUSE_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index_type'(csr_index))
            CSR_RISE:  cfg_ff.rise  <= csr_wdata[SAMPLE_BITS-1:0];
            CSR_FALL:  cfg_ff.fall  <= csr_wdata[SAMPLE_BITS-1:0];
            CSR_TPS:   cfg_ff.tps   <= csr_wdata[7:0];
            CSR_PAUSE: cfg_ff.pause <= csr_wdata[9:0];
         endcase
      end
   end

   // handshake: the result register frees the input register
   assign out_adv    = !out_valid_ff || rsp_tready;
   assign req_tready = !in_valid_ff || out_adv;
   assign fire       = in_valid_ff && out_adv;

   // unpack request, servo index saturated to the last servo
   always_comb begin
      in_item_in.kind   = req_kind_type'(req_tuser);
      in_item_in.servo  = req_tdata[1:0];
      in_item_in.amount = req_tdata[9:2];
      in_item_in.sample = req_tdata[10 +: SAMPLE_BITS];
      in_item_in.button = req_tdata[10 + SAMPLE_BITS];
      if ({3'b000, req_tdata[1:0]} >= NumServosW) begin
         in_item_in.servo = MaxSel;
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_item_ff <= in_item_in;
      end
   end

   ssds_step u_step (
      .cfg       (cfg_ff),
      .item      (in_item_ff),
      .state_cur (state_ff),
      .state_nxt (state_in),
      .result    (step_res)
   );

   // sequencer state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.active   <= 1'b0;
         state_ff.leg      <= LEG_DOWN;
         state_ff.angle    <= ANGLE_REST;
         state_ff.hold     <= 10'd0;
         state_ff.cycles   <= 10'd0;
         state_ff.target   <= 8'd0;
         state_ff.servo    <= 2'd0;
         state_ff.det_high <= 1'b1;
         state_ff.count    <= 16'd0;
      end else if (fire) begin
         state_ff <= state_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (fire) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         out_res_ff <= step_res;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {4'b0000, out_res_ff.count, out_res_ff.led, out_res_ff.angle,
                        out_res_ff.channel, out_res_ff.running};
   assign rsp_tlast  = out_res_ff.done;

   // a done item always reports the run as stopped
   a_done_stops: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tlast) |-> !rsp_tdata[0])
      else $error("run_done with running still set");

   // commanded angle never exceeds the top of the sweep
   a_angle_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[10:3] <= ANGLE_TOP))
      else $error("servo angle beyond top");

   // an idle sequencer rests at the start of the down leg
   a_idle_rest: assert property (@(posedge clock) disable iff (reset)
      !state_ff.active |-> (state_ff.leg == LEG_DOWN && state_ff.angle == ANGLE_REST))
      else $error("idle sequencer not at rest position");

endmodule

// File: sv/ssds_step.sv
module ssds_step
   import ssds_pkg::*;
(
   input  cfg_type       cfg,
   input  item_type      item,
   input  seq_state_type state_cur,
   output seq_state_type state_nxt,
   output result_type    result
);

   logic        rise_hit;
   logic        det_mid;
   logic        det_next;
   logic [1:0]  cnt_inc;
   logic [16:0] cnt_sum;
   logic [15:0] cnt_next;
   logic [7:0]  step_len;
   logic [9:0]  leg_len;
   logic [9:0]  hold_inc;
   logic [9:0]  cycle_inc;
   logic [10:0] cycle_limit;
   logic        run_end;

   // hysteresis detector and saturating item count
   always_comb begin
      rise_hit = !state_cur.det_high && (item.sample > cfg.rise);
      det_mid  = state_cur.det_high | rise_hit;
      det_next = det_mid && !(item.sample < cfg.fall);
      cnt_inc  = {1'b0, rise_hit} + {1'b0, item.button};
      cnt_sum  = {1'b0, state_cur.count} + {15'd0, cnt_inc};
      cnt_next = cnt_sum[16] ? 16'hFFFF : cnt_sum[15:0];
   end

   // hold lengths and counter increments
   always_comb begin
      step_len    = (cfg.tps == 8'd0) ? 8'd1 : cfg.tps;
      leg_len     = (state_cur.leg == LEG_PAUSE) ? cfg.pause : {2'b00, step_len};
      hold_inc    = state_cur.hold + 10'd1;
      cycle_inc   = state_cur.cycles + 10'd1;
      cycle_limit = {2'b00, state_cur.target, 1'b0} + 11'd3;
   end

   // next sequencer state
   always_comb begin
      state_nxt = state_cur;
      run_end   = 1'b0;
      if (item.kind == REQ_START) begin
         state_nxt.active   = 1'b1;
         state_nxt.leg      = LEG_DOWN;
         state_nxt.angle    = ANGLE_REST;
         state_nxt.hold     = 10'd0;
         state_nxt.cycles   = 10'd0;
         state_nxt.target   = item.amount;
         state_nxt.servo    = item.servo;
         state_nxt.det_high = 1'b1;
         state_nxt.count    = 16'd0;
      end else if (state_cur.active) begin
         state_nxt.det_high = det_next;
         state_nxt.count    = cnt_next;
         if (hold_inc < leg_len) begin
            state_nxt.hold = hold_inc;
         end else begin
            state_nxt.hold = 10'd0;
            unique case (state_cur.leg)
               LEG_DOWN: begin
                  if (state_cur.angle > 8'd0) begin
                     state_nxt.angle = state_cur.angle - 8'd1;
                  end else begin
                     state_nxt.leg = (cfg.pause != 10'd0) ? LEG_PAUSE : LEG_UP;
                  end
               end
               LEG_PAUSE: begin
                  state_nxt.leg   = LEG_UP;
                  state_nxt.angle = 8'd0;
               end
               LEG_UP: begin
                  if (state_cur.angle < ANGLE_TOP) begin
                     state_nxt.angle = state_cur.angle + 8'd1;
                  end else begin
                     state_nxt.leg   = LEG_RETURN;
                     state_nxt.angle = ANGLE_TOP;
                  end
               end
               LEG_RETURN: begin
                  if (state_cur.angle > ANGLE_REST) begin
                     state_nxt.angle = state_cur.angle - 8'd1;
                  end else begin
                     // end of one sweep cycle: check for run completion
                     state_nxt.cycles = cycle_inc;
                     state_nxt.leg    = LEG_DOWN;
                     state_nxt.angle  = ANGLE_REST;
                     if ((cnt_next >= {8'd0, state_cur.target}) ||
                         ({1'b0, cycle_inc} >= cycle_limit)) begin
                        state_nxt.active = 1'b0;
                        run_end          = 1'b1;
                     end
                  end
               end
            endcase
         end
      end
   end

   // result fields
   always_comb begin
      if (item.kind == REQ_START) begin
         result.running = 1'b1;
         result.channel = item.servo;
         result.angle   = ANGLE_REST;
         result.led     = 1'b1;
         result.count   = 16'd0;
         result.done    = 1'b0;
      end else if (state_cur.active) begin
         result.running = state_nxt.active;
         result.channel = state_cur.servo;
         result.angle   = state_cur.angle;
         result.led     = (state_cur.leg != LEG_UP);
         result.count   = cnt_next;
         result.done    = run_end;
      end else begin
         result.running = 1'b0;
         result.channel = state_cur.servo;
         result.angle   = state_cur.angle;
         result.led     = 1'b0;
         result.count   = state_cur.count;
         result.done    = 1'b0;
      end
   end

endmodule

// File: sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top
   import ssds_pkg::*;
;

   localparam int         NUM_SERVO_CH = 4;
   localparam logic [1:0] SERVO_LAST   = 2'(NUM_SERVO_CH - 1);
   localparam int         RANDOM_ITEMS = 1730;
   localparam int         QUIET_FROM   = 1500;
   localparam int         STALL_LIMIT  = 500;

   // sweep sequencer predictor plus queue of expected result items
   class dispense_scoreboard;
      logic [11:0] rise_thr;
      logic [11:0] fall_thr;
      logic [7:0]  step_ticks;
      logic [9:0]  pause_len;
      logic        active;
      leg_type     leg;
      logic [7:0]  angle;
      logic [9:0]  hold;
      logic [9:0]  cycles;
      logic [7:0]  target;
      logic [1:0]  servo;
      logic        det_high;
      logic [15:0] count;
      result_type  expected_q[$];
      int          errors;
      int          items;
      int          starts;
      int          completions;

      function new();
         rise_thr    = RISE_RESET;
         fall_thr    = FALL_RESET;
         step_ticks  = TPS_RESET;
         pause_len   = PAUSE_RESET;
         active      = 1'b0;
         leg         = LEG_DOWN;
         angle       = ANGLE_REST;
         hold        = '0;
         cycles      = '0;
         target      = '0;
         servo       = '0;
         det_high    = 1'b1;
         count       = '0;
         errors      = 0;
         items       = 0;
         starts      = 0;
         completions = 0;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      function void write_reg(csr_index_type idx, logic [11:0] value);
         case (idx)
            CSR_RISE:  rise_thr = value;
            CSR_FALL:  fall_thr = value;
            CSR_TPS:   step_ticks = value[7:0];
            CSR_PAUSE: pause_len = value[9:0];
            default: ;
         endcase
      endfunction

      // saturating dispensed count
      function void count_one();
         if (count != 16'hFFFF) count++;
      endfunction

      function void note_item(item_type it);
         result_type r;
         logic [9:0] len;
         r = '0;
         items++;
         if (it.kind == REQ_START) begin
            // start (or restart) a run from the rest angle
            starts++;
            servo    = (it.servo > SERVO_LAST) ? SERVO_LAST : it.servo;
            target   = it.amount;
            active   = 1'b1;
            leg      = LEG_DOWN;
            angle    = ANGLE_REST;
            hold     = '0;
            cycles   = '0;
            det_high = 1'b1;
            count    = '0;
            r.angle  = ANGLE_REST;
            r.led    = 1'b1;
         end else if (active) begin
            r.angle = angle;
            r.led   = (leg != LEG_UP);
            // hysteresis detector, rise test ahead of fall test
            if (!det_high && it.sample > rise_thr) begin
               det_high = 1'b1;
               count_one();
            end
            if (det_high && it.sample < fall_thr) det_high = 1'b0;
            if (it.button) count_one();
            // hold timer and leg sequencing
            if (leg == LEG_PAUSE) len = pause_len;
            else len = (step_ticks == '0) ? 10'd1 : 10'(step_ticks);
            hold = hold + 10'd1;
            if (hold >= len) begin
               hold = '0;
               case (leg)
                  LEG_DOWN: begin
                     if (angle > 8'd0) angle--;
                     else if (pause_len != '0) leg = LEG_PAUSE;
                     else leg = LEG_UP;
                  end
                  LEG_PAUSE: begin
                     leg   = LEG_UP;
                     angle = 8'd0;
                  end
                  LEG_UP: begin
                     if (angle < ANGLE_TOP) angle++;
                     else begin
                        leg   = LEG_RETURN;
                        angle = ANGLE_TOP;
                     end
                  end
                  default: begin
                     if (angle > ANGLE_REST) angle--;
                     else begin
                        // end of one sweep cycle
                        cycles = cycles + 10'd1;
                        leg    = LEG_DOWN;
                        angle  = ANGLE_REST;
                        if (count >= target || int'(cycles) >= 2 * int'(target) + 3) begin
                           active = 1'b0;
                           r.done = 1'b1;
                           completions++;
                        end
                     end
                  end
               endcase
            end
         end else begin
            r.angle = angle;
         end
         r.running = active;
         r.channel = servo;
         r.count   = count;
         expected_q.push_back(r);
      endfunction

      function void compare(string name, logic [15:0] exp_v, logic [15:0] act_v);
         if (act_v !== exp_v) begin
            errors++;
            if (errors <= 40) $error("%s expected %0d actual %0d", name, exp_v, act_v);
         end
      endfunction

      function void check_result(logic [RSP_TDATA_W-1:0] data, logic last);
         result_type e;
         if (expected_q.size() == 0) begin
            errors++;
            if (errors <= 40) $error("result item arrived with no expectation waiting");
            return;
         end
         e = expected_q.pop_front();
         compare("running", 16'(e.running), 16'(data[0]));
         compare("servo_channel", 16'(e.channel), 16'(data[2:1]));
         compare("servo_angle", 16'(e.angle), 16'(data[10:3]));
         compare("led_on", 16'(e.led), 16'(data[11]));
         compare("dispensed_count", e.count, data[27:12]);
         compare("run_done", 16'(e.done), 16'(last));
      endfunction
   endclass

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   csr_index_type          csr_index = CSR_RISE;
   logic [11:0]            csr_wdata = '0;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;  // servo_select, dispense_amount, light_sample,
                                            // button_press
   logic                   req_tuser = 1'b1;  // req_type
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b1;
   logic [RSP_TDATA_W-1:0] rsp_tdata;  // running, servo_channel, servo_angle, led_on,
                                       // dispensed_count
   logic                   rsp_tlast;  // run_done

   dispense_scoreboard sb = new();
   int                 quiet_cycles = 0;
   int                 stall_left = 0;
   int                 settings_used = 1;
   logic               idle_enable = 1'b1;

   servo_sweep_dispense_sequencer #(
      .NUM_SERVOS (NUM_SERVO_CH)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   // 8 ns clock
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // handshake monitor: register writes, accepted items, results
   always @(posedge clock) begin : monitor
      item_type seen;
      logic     moved;
      moved = 1'b0;
      if (!reset) begin
         if (csr_valid && csr_ready) begin
            sb.write_reg(csr_index, csr_wdata);
            moved = 1'b1;
         end
         if (req_tvalid && req_tready) begin
            seen.kind   = req_kind_type'(req_tuser);
            seen.servo  = req_tdata[1:0];
            seen.amount = req_tdata[9:2];
            seen.sample = req_tdata[21:10];
            seen.button = req_tdata[22];
            sb.note_item(seen);
            moved = 1'b1;
         end
         if (rsp_tvalid && rsp_tready) begin
            sb.check_result(rsp_tdata, rsp_tlast);
            moved = 1'b1;
         end
         quiet_cycles = moved ? 0 : quiet_cycles + 1;
      end
   end

   // result side back-pressure in bursts
   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_tready = 1'b0;
      end else if (idle_enable && $urandom_range(0, 7) == 0) begin
         stall_left = $urandom_range(0, 10);
         rsp_tready = 1'b0;
      end else begin
         rsp_tready = 1'b1;
      end
   end

   // watchdog on handshake activity
   initial begin
      wait (quiet_cycles >= STALL_LIMIT);
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   function automatic item_type make_item(req_kind_type k, logic [1:0] s, logic [7:0] a,
                                          logic [11:0] smp, logic b);
      item_type it;
      it.kind   = k;
      it.servo  = s;
      it.amount = a;
      it.sample = smp;
      it.button = b;
      return it;
   endfunction

   // mostly ticks of a run; starts when idle, rare restarts, small amounts
   function automatic item_type random_item();
      item_type it;
      if (!sb.active) it.kind = ($urandom_range(0, 3) == 0) ? REQ_START : REQ_TICK;
      else it.kind = ($urandom_range(0, 599) == 0) ? REQ_START : REQ_TICK;
      it.servo = 2'($urandom_range(0, 3));
      if ($urandom_range(0, 9) == 0) it.amount = 8'($urandom_range(0, 255));
      else it.amount = 8'($urandom_range(0, 3));
      case ($urandom_range(0, 5))
         0: it.sample = 12'd0;
         1: it.sample = 12'd4095;
         2: it.sample = sb.rise_thr;
         3: it.sample = sb.fall_thr;
         default: it.sample = 12'($urandom_range(0, 4095));
      endcase
      it.button = ($urandom_range(0, 15) == 0);
      return it;
   endfunction

   task automatic send_item(item_type it);
      @(negedge clock);
      req_tvalid = 1'b1;
      req_tuser  = it.kind;
      req_tdata  = {1'b0, it.button, it.sample, it.amount, it.servo};
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic pause_sender(int n);
      repeat (n) begin
         @(negedge clock);
         req_tvalid = 1'b0;
      end
   endtask

   // stop sending and wait for every expected result
   task automatic settle();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (sb.pending() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic csr_write(csr_index_type idx, logic [11:0] value);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_wdata = value;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic apply_settings(logic [11:0] rise, logic [11:0] fall, logic [7:0] tps,
                                 logic [9:0] pause);
      settle();
      csr_write(CSR_RISE, rise);
      csr_write(CSR_FALL, fall);
      csr_write(CSR_TPS, 12'(tps));
      csr_write(CSR_PAUSE, 12'(pause));
      @(negedge clock);
      csr_valid = 1'b0;
      settings_used++;
   endtask

   initial begin : stimulus
      int          sent;
      int          phase;
      int          plen;
      logic [11:0] rise;
      logic [11:0] fall;
      logic [7:0]  tps;
      logic [9:0]  pause;
      sent  = 0;
      phase = 0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // default thresholds: ticks while idle, full-range start, restart mid-run
      send_item(make_item(REQ_TICK, 2'd0, 8'd0, 12'd4095, 1'b1));
      send_item(make_item(REQ_TICK, 2'd3, 8'd255, 12'd0, 1'b0));
      send_item(make_item(REQ_START, 2'd3, 8'd255, 12'd0, 1'b0));
      send_item(make_item(REQ_TICK, 2'd0, 8'd0, 12'd0, 1'b0));
      send_item(make_item(REQ_TICK, 2'd0, 8'd0, 12'd4095, 1'b0));
      send_item(make_item(REQ_TICK, 2'd0, 8'd0, 12'd0, 1'b1));
      send_item(make_item(REQ_TICK, 2'd1, 8'd170, 12'd4095, 1'b1));
      send_item(make_item(REQ_TICK, 2'd0, 8'd0, 12'd500, 1'b0));
      send_item(make_item(REQ_START, 2'd2, 8'd0, 12'd2730, 1'b1));
      send_item(make_item(REQ_TICK, 2'd0, 8'd0, 12'd1365, 1'b0));

      // overlapping thresholds, zero step length, pause skipped, zero amount
      apply_settings(12'd0, 12'd4095, 8'd0, 10'd0);
      send_item(make_item(REQ_START, 2'd1, 8'd0, 12'd0, 1'b0));
      send_item(make_item(REQ_TICK, 2'd0, 8'd0, 12'd4095, 1'b0));
      send_item(make_item(REQ_TICK, 2'd0, 8'd0, 12'd0, 1'b0));
      send_item(make_item(REQ_TICK, 2'd0, 8'd0, 12'd1, 1'b1));
      send_item(make_item(REQ_TICK, 2'd0, 8'd0, 12'd4094, 1'b0));
      send_item(make_item(REQ_TICK, 2'd0, 8'd0, 12'd2048, 1'b1));
      send_item(make_item(REQ_TICK, 2'd0, 8'd0, 12'd4095, 1'b0));

      // random phases, each under its own register settings
      while (sent < RANDOM_ITEMS) begin
         if (phase == 1) begin
            apply_settings(12'd4095, 12'd0, 8'd255, 10'd1023);
         end else if (phase > 1) begin
            case ($urandom_range(0, 5))
               0: rise = 12'd0;
               1: rise = 12'd4095;
               default: rise = 12'($urandom_range(0, 4095));
            endcase
            case ($urandom_range(0, 5))
               0: fall = 12'd0;
               1: fall = 12'd4095;
               default: fall = 12'($urandom_range(0, 4095));
            endcase
            case ($urandom_range(0, 7))
               0: tps = 8'd0;
               1: tps = 8'd255;
               2, 3: tps = 8'($urandom_range(2, 6));
               default: tps = 8'd1;
            endcase
            case ($urandom_range(0, 7))
               0: pause = 10'd1023;
               1, 2, 3: pause = 10'd0;
               default: pause = 10'($urandom_range(1, 30));
            endcase
            apply_settings(rise, fall, tps, pause);
         end
         plen = (phase == 1) ? 120 : $urandom_range(150, 350);
         idle_enable = (sent < QUIET_FROM) && ($urandom_range(0, 3) != 0);
         repeat (plen) begin
            if (sent < RANDOM_ITEMS) begin
               // no idling on either side in the closing stretch
               if (sent >= QUIET_FROM) idle_enable = 1'b0;
               if (idle_enable && $urandom_range(0, 7) == 0) pause_sender($urandom_range(1, 11));
               send_item(random_item());
               sent++;
            end
         end
         phase++;
      end

      idle_enable = 1'b0;
      settle();
      repeat (8) @(posedge clock);
      $display("run covered %0d items with %0d run starts and %0d completed runs",
               sb.items, sb.starts, sb.completions);
      $display("across %0d register settings, %0d field mismatches",
               settings_used, sb.errors);
      if (sb.errors == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
